/* hdl/imc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imc_pkg
// Shared types and constants of the IMU mounting-correction block.
// ----------------------------------------------------------------------------
package imc_pkg;

  localparam int SampleWidth  = 16;
  localparam int CoefFracBits = 15;
  localparam int CoefWidth    = CoefFracBits + 2;
  localparam int AngleWidth   = 16;
  localparam int ScaleWidth   = 16;
  localparam int ScaleFrac    = 14;
  localparam int AddrWidth    = 5;
  localparam int RegIdxWidth  = 3;

  localparam logic [RegIdxWidth-1:0] RegYaw    = 3'd0;
  localparam logic [RegIdxWidth-1:0] RegPitch  = 3'd1;
  localparam logic [RegIdxWidth-1:0] RegRoll   = 3'd2;
  localparam logic [RegIdxWidth-1:0] RegScaleX = 3'd3;
  localparam logic [RegIdxWidth-1:0] RegScaleY = 3'd4;
  localparam logic [RegIdxWidth-1:0] RegScaleZ = 3'd5;

  typedef logic signed [CoefWidth-1:0] coef_t;
  typedef coef_t [8:0] coef_arr_t;

  typedef struct packed {
    logic signed [AngleWidth-1:0] yaw;
    logic signed [AngleWidth-1:0] pitch;
    logic signed [AngleWidth-1:0] roll;
    logic                         restart;
  } angle_cfg_t;

endpackage

/* hdl/imu_mounting_correction.sv */
`timescale 1ns / 1ps
// four-stage rotation pipeline: input, product, sum and output registers
// throughput: one request per cycle while the output is not stalled
// reset and every angle register write start a coefficient computation in
// the shared-multiplier unit; input stalls until it is done
// rst_ni clears all valid bits, angles to 0 and gyro scales to one
// ----------------------------------------------------------------------------
// imu_mounting_correction
// Gyro scaling and rotation of gyro and accel vectors by a mounting matrix.
// ----------------------------------------------------------------------------
module imu_mounting_correction (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [imc_pkg::AddrWidth-1:0]          paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [imc_pkg::SampleWidth-1:0] gyro_x_i,
  input  logic signed [imc_pkg::SampleWidth-1:0] gyro_y_i,
  input  logic signed [imc_pkg::SampleWidth-1:0] gyro_z_i,
  input  logic signed [imc_pkg::SampleWidth-1:0] accel_x_i,
  input  logic signed [imc_pkg::SampleWidth-1:0] accel_y_i,
  input  logic signed [imc_pkg::SampleWidth-1:0] accel_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [imc_pkg::SampleWidth-1:0] out_gyro_x_o,
  output logic signed [imc_pkg::SampleWidth-1:0] out_gyro_y_o,
  output logic signed [imc_pkg::SampleWidth-1:0] out_gyro_z_o,
  output logic signed [imc_pkg::SampleWidth-1:0] out_accel_x_o,
  output logic signed [imc_pkg::SampleWidth-1:0] out_accel_y_o,
  output logic signed [imc_pkg::SampleWidth-1:0] out_accel_z_o,
  output logic                                   clipped_o
);
  import imc_pkg::*;

  localparam int GsWidth   = SampleWidth + 3;
  localparam int GpWidth   = SampleWidth + ScaleWidth + 1;
  localparam int ProdWidth = CoefWidth + GsWidth;
  localparam int SumWidth  = ProdWidth + 2;

  // configuration registers
  logic [AngleWidth-1:0] yaw_q, pitch_q, roll_q;
  logic [ScaleWidth-1:0] scale_q [3];
  logic                  wr_en;
  logic [RegIdxWidth-1:0] wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = paddr[AddrWidth-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q   <= '0;
      pitch_q <= '0;
      roll_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        scale_q[i] <= ScaleWidth'(1 << ScaleFrac);
      end
    end else if (wr_en) begin
      case (wr_idx)
        RegYaw:    yaw_q      <= pwdata[AngleWidth-1:0];
        RegPitch:  pitch_q    <= pwdata[AngleWidth-1:0];
        RegRoll:   roll_q     <= pwdata[AngleWidth-1:0];
        RegScaleX: scale_q[0] <= pwdata[ScaleWidth-1:0];
        RegScaleY: scale_q[1] <= pwdata[ScaleWidth-1:0];
        RegScaleZ: scale_q[2] <= pwdata[ScaleWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      RegYaw:    prdata = 32'(yaw_q);
      RegPitch:  prdata = 32'(pitch_q);
      RegRoll:   prdata = 32'(roll_q);
      RegScaleX: prdata = 32'(scale_q[0]);
      RegScaleY: prdata = 32'(scale_q[1]);
      RegScaleZ: prdata = 32'(scale_q[2]);
      default:   prdata = '0;
    endcase
  end

  // coefficient unit
  angle_cfg_t cfg;
  coef_arr_t  coef;
  logic       coef_ready;

  assign cfg.yaw     = yaw_q;
  assign cfg.pitch   = pitch_q;
  assign cfg.roll    = roll_q;
  assign cfg.restart = wr_en && (wr_idx == RegYaw || wr_idx == RegPitch || wr_idx == RegRoll);

  imc_coef u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .coef_o  (coef),
    .ready_o (coef_ready)
  );

  // pipeline control
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv, accept;

  assign adv        = !(v4_q && out_stall_i);
  assign in_stall_o = !adv || !coef_ready;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: gyro scaling
  logic signed [SampleWidth-1:0] gin [3];
  logic signed [SampleWidth-1:0] ain [3];
  logic signed [GpWidth-1:0]     gp  [3];
  logic [GpWidth-1:0]            gmag [3];
  logic [GpWidth-1:0]            grnd [3];
  logic signed [GsWidth-1:0]     gs  [3];
  logic signed [GsWidth-1:0]     s1_q [6];

  assign gin[0] = gyro_x_i;
  assign gin[1] = gyro_y_i;
  assign gin[2] = gyro_z_i;
  assign ain[0] = accel_x_i;
  assign ain[1] = accel_y_i;
  assign ain[2] = accel_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gp[i]   = GpWidth'(gin[i]) * $signed({1'b0, scale_q[i]});
      gmag[i] = gp[i][GpWidth-1] ? GpWidth'(-gp[i]) : GpWidth'(gp[i]);
      grnd[i] = (gmag[i] + GpWidth'(1 << (ScaleFrac - 1))) >> ScaleFrac;
      gs[i]   = gp[i][GpWidth-1] ? GsWidth'(-grnd[i]) : GsWidth'(grnd[i]);
    end
  end

  // stage 2: coefficient products
  logic signed [ProdWidth-1:0] prod_q [6][3];
  // stage 3: row sums
  logic signed [SumWidth-1:0]  sum_q [6];
  // stage 4: rounding and saturation
  logic signed [SampleWidth-1:0] res   [6];
  logic [5:0]                    clip;
  logic signed [SampleWidth-1:0] out_q [6];
  logic                          clip_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_q[i]     <= gs[i];
        s1_q[3 + i] <= GsWidth'(ain[i]);
      end
      for (int o = 0; o < 6; o++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[o][c] <= ProdWidth'($signed(coef[(o % 3) * 3 + c]))
                          * ProdWidth'(s1_q[(o / 3) * 3 + c]);
        end
        sum_q[o] <= SumWidth'(prod_q[o][0]) + SumWidth'(prod_q[o][1])
                    + SumWidth'(prod_q[o][2]);
        out_q[o] <= res[o];
      end
      clip_q <= |clip;
    end
  end

  logic                neg [6];
  logic [SumWidth-1:0] smag [6];
  logic [SumWidth-1:0] srnd [6];
  localparam logic [SumWidth-1:0] LimNeg = SumWidth'(1) << (SampleWidth - 1);
  localparam logic [SumWidth-1:0] LimPos = LimNeg - SumWidth'(1);

  always_comb begin
    for (int o = 0; o < 6; o++) begin
      neg[o]  = sum_q[o][SumWidth-1];
      smag[o] = neg[o] ? SumWidth'(-sum_q[o]) : SumWidth'(sum_q[o]);
      srnd[o] = (smag[o] + SumWidth'(1 << (CoefFracBits - 1))) >> CoefFracBits;
      if (neg[o]) begin
        clip[o] = srnd[o] > LimNeg;
        res[o]  = clip[o] ? SampleWidth'(-LimNeg) : SampleWidth'(-srnd[o]);
      end else begin
        clip[o] = srnd[o] > LimPos;
        res[o]  = clip[o] ? SampleWidth'(LimPos) : SampleWidth'(srnd[o]);
      end
    end
  end

  assign out_valid_o   = v4_q;
  assign out_gyro_x_o  = out_q[0];
  assign out_gyro_y_o  = out_q[1];
  assign out_gyro_z_o  = out_q[2];
  assign out_accel_x_o = out_q[3];
  assign out_accel_y_o = out_q[4];
  assign out_accel_z_o = out_q[5];
  assign clipped_o     = clip_q;

  localparam logic signed [SampleWidth-1:0] RailHi = SampleWidth'(LimPos);
  localparam logic signed [SampleWidth-1:0] RailLo = SampleWidth'(-LimNeg);

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q)
    else $error("accepted request did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable({v1_q, v2_q, v3_q, v4_q}))
    else $error("pipeline valid bits moved during stall");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !coef_ready |-> in_stall_o)
    else $error("request taken while coefficients not ready");

  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |->
      (out_q[0] == RailHi || out_q[0] == RailLo || out_q[1] == RailHi ||
       out_q[1] == RailLo || out_q[2] == RailHi || out_q[2] == RailLo ||
       out_q[3] == RailHi || out_q[3] == RailLo || out_q[4] == RailHi ||
       out_q[4] == RailLo || out_q[5] == RailHi || out_q[5] == RailLo))
    else $error("clip flag set with no axis at a rail");

endmodule

/* hdl/imc_coef.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imc_coef
// Sequential rotation-matrix unit: sine and cosine of the three mounting
// angles by a fixed-point polynomial, then the nine matrix coefficients,
// all through one shared multiplier.
// ----------------------------------------------------------------------------
module imc_coef (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  imc_pkg::angle_cfg_t   cfg_i,
  output imc_pkg::coef_arr_t    coef_o,
  output logic                  ready_o
);
  import imc_pkg::*;

  localparam int XWidth   = 26;
  localparam int ZWidth   = 31;
  localparam logic        DivLast = 1'b1;
  localparam logic [4:0]  MatLast = 5'd24;
  localparam logic [31:0] SinA = 32'd1686629713;
  localparam logic [31:0] SinB = 32'd688904866;
  localparam logic [31:0] SinC = 32'd76016977;
  // 2^30 = 119304 * 9000 + 5824, and ceil(2^40 / 9000) for the remainder term
  localparam logic [ZWidth-1:0] ZPerStep = 31'd119304;
  localparam logic [XWidth-1:0] ZRemStep = 26'd5824;
  localparam logic [XWidth-1:0] HalfDiv  = 26'd4500;
  localparam logic [31:0]       RecipDiv = 32'd122167959;

  typedef enum logic [2:0] {StReduce, StDiv, StPoly, StMat, StIdle} state_e;

  state_e             state_q;
  logic [2:0]         idx_q;
  logic               cnt_q;
  logic [1:0]         pstep_q;
  logic [4:0]         mstep_q;
  logic               valid_q;
  logic [1:0]         quad_q;
  logic [13:0]        tf_q;
  logic [XWidth-1:0]  x_q;
  logic [ZWidth-1:0]  base_q;
  logic [ZWidth-1:0]  z_q;
  logic [ZWidth-1:0]  z2_q;
  logic [ZWidth-1:0]  p_q;
  logic signed [31:0] s_q [6];
  logic signed [31:0] t0_q, t1_q;
  coef_t              coef_q [9];

  // angle reduction
  logic signed [AngleWidth-1:0] ang;
  logic signed [17:0] a_s, r_s;
  logic [15:0] r_u;
  logic [1:0]  quad;
  logic [13:0] t_u, tf_u;

  always_comb begin
    case (idx_q[2:1])
      2'd0:    ang = cfg_i.yaw;
      2'd1:    ang = cfg_i.pitch;
      default: ang = cfg_i.roll;
    endcase
    a_s = $signed({{2{ang[AngleWidth-1]}}, ang}) + (idx_q[0] ? 18'sd9000 : 18'sd0);
    if (a_s < 18'sd0) begin
      r_s = a_s + 18'sd36000;
    end else if (a_s >= 18'sd36000) begin
      r_s = a_s - 18'sd36000;
    end else begin
      r_s = a_s;
    end
    r_u = r_s[15:0];
    if (r_u >= 16'd27000) begin
      quad = 2'd3;
      t_u  = 14'(r_u - 16'd27000);
    end else if (r_u >= 16'd18000) begin
      quad = 2'd2;
      t_u  = 14'(r_u - 16'd18000);
    end else if (r_u >= 16'd9000) begin
      quad = 2'd1;
      t_u  = 14'(r_u - 16'd9000);
    end else begin
      quad = 2'd0;
      t_u  = r_u[13:0];
    end
    tf_u = quad[0] ? 14'd9000 - t_u : t_u;
  end

  // matrix sequencer
  logic               is_mul, dst_t1;
  logic signed [31:0] op_a, op_b;
  logic signed [32:0] comb_v;
  logic [3:0]         cidx;
  logic signed [31:0] sy, cy, sp, cp, sr, cr;
  assign sy = s_q[0];
  assign cy = s_q[1];
  assign sp = s_q[2];
  assign cp = s_q[3];
  assign sr = s_q[4];
  assign cr = s_q[5];

  logic signed [32:0] t0e, t1e;
  assign t0e = {t0_q[31], t0_q};
  assign t1e = {t1_q[31], t1_q};

  always_comb begin
    is_mul = 1'b1;
    dst_t1 = 1'b0;
    op_a   = cy;
    op_b   = cr;
    comb_v = t0e;
    cidx   = 4'd0;
    case (mstep_q)
      5'd0:  begin op_a = cy; op_b = cr; end
      5'd1:  begin op_a = sy; op_b = sp; dst_t1 = 1'b1; end
      5'd2:  begin op_a = t1_q; op_b = sr; dst_t1 = 1'b1; end
      5'd3:  begin is_mul = 1'b0; comb_v = t0e + t1e; cidx = 4'd0; end
      5'd4:  begin op_a = cp; op_b = sy; end
      5'd5:  begin is_mul = 1'b0; comb_v = t0e; cidx = 4'd1; end
      5'd6:  begin op_a = cy; op_b = sr; end
      5'd7:  begin op_a = cr; op_b = sy; dst_t1 = 1'b1; end
      5'd8:  begin op_a = t1_q; op_b = sp; dst_t1 = 1'b1; end
      5'd9:  begin is_mul = 1'b0; comb_v = t0e - t1e; cidx = 4'd2; end
      5'd10: begin op_a = cy; op_b = sp; end
      5'd11: begin op_a = t0_q; op_b = sr; end
      5'd12: begin op_a = cr; op_b = sy; dst_t1 = 1'b1; end
      5'd13: begin is_mul = 1'b0; comb_v = t0e - t1e; cidx = 4'd3; end
      5'd14: begin op_a = cy; op_b = cp; end
      5'd15: begin is_mul = 1'b0; comb_v = t0e; cidx = 4'd4; end
      5'd16: begin op_a = sy; op_b = sr; end
      5'd17: begin op_a = cy; op_b = cr; dst_t1 = 1'b1; end
      5'd18: begin op_a = t1_q; op_b = sp; dst_t1 = 1'b1; end
      5'd19: begin is_mul = 1'b0; comb_v = -t0e - t1e; cidx = 4'd5; end
      5'd20: begin op_a = cp; op_b = sr; end
      5'd21: begin is_mul = 1'b0; comb_v = -t0e; cidx = 4'd6; end
      5'd22: begin is_mul = 1'b0; comb_v = {sp[31], sp}; cidx = 4'd7; end
      5'd23: begin op_a = cp; op_b = cr; end
      5'd24: begin is_mul = 1'b0; comb_v = t0e; cidx = 4'd8; end
      default: begin is_mul = 1'b0; comb_v = t0e; cidx = 4'd8; end
    endcase
  end

  // shared multiplier
  logic [31:0] mag_a, mag_b, poly_a, poly_b, mul_a, mul_b, rnd30;
  logic [63:0] prod;
  logic [ZWidth-1:0] z;
  logic signed [31:0] mul30, s_sig;
  assign z     = z_q;
  assign mag_a = op_a[31] ? 32'(-op_a) : 32'(op_a);
  assign mag_b = op_b[31] ? 32'(-op_b) : 32'(op_b);

  always_comb begin
    case (pstep_q)
      2'd0:    begin poly_a = {1'b0, z};   poly_b = {1'b0, z};    end
      2'd1:    begin poly_a = SinC;        poly_b = {1'b0, z2_q}; end
      2'd2:    begin poly_a = {1'b0, p_q}; poly_b = {1'b0, z2_q}; end
      default: begin poly_a = {1'b0, p_q}; poly_b = {1'b0, z};    end
    endcase
  end

  assign mul_a = (state_q == StMat) ? mag_a :
                 (state_q == StDiv) ? 32'(x_q) : poly_a;
  assign mul_b = (state_q == StMat) ? mag_b :
                 (state_q == StDiv) ? RecipDiv : poly_b;
  assign prod  = 64'(mul_a) * 64'(mul_b);
  assign rnd30 = 32'(prod[63:30]) + {31'd0, prod[29]};
  assign mul30 = (op_a[31] != op_b[31]) ? -$signed(rnd30) : $signed(rnd30);
  assign s_sig = quad_q[1] ? -$signed(prod[61:30]) : $signed(prod[61:30]);

  function automatic coef_t to_coef(input logic signed [32:0] v);
    logic        neg;
    logic [32:0] mag;
    logic [33:0] rnd, lim;
    coef_t       res;
    neg = v[32];
    mag = neg ? 33'(-v) : 33'(v);
    rnd = ({1'b0, mag} + 34'(1 << (29 - CoefFracBits))) >> (30 - CoefFracBits);
    lim = 34'(1) << (CoefFracBits + 1);
    if (neg) begin
      res = (rnd > lim) ? CoefWidth'(-lim) : CoefWidth'(-rnd);
    end else begin
      res = (rnd > lim - 34'd1) ? CoefWidth'(lim - 34'd1) : CoefWidth'(rnd);
    end
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StReduce;
      idx_q   <= 3'd0;
      cnt_q   <= 1'b0;
      pstep_q <= 2'd0;
      mstep_q <= 5'd0;
      valid_q <= 1'b0;
    end else if (cfg_i.restart) begin
      state_q <= StReduce;
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      case (state_q)
        StReduce: begin
          cnt_q   <= 1'b0;
          state_q <= StDiv;
        end
        StDiv: begin
          if (cnt_q == DivLast) begin
            pstep_q <= 2'd0;
            state_q <= StPoly;
          end else begin
            cnt_q <= 1'b1;
          end
        end
        StPoly: begin
          pstep_q <= pstep_q + 2'd1;
          if (pstep_q == 2'd3) begin
            if (idx_q == 3'd5) begin
              mstep_q <= 5'd0;
              state_q <= StMat;
            end else begin
              idx_q   <= idx_q + 3'd1;
              state_q <= StReduce;
            end
          end
        end
        StMat: begin
          if (mstep_q == MatLast) begin
            valid_q <= 1'b1;
            state_q <= StIdle;
          end else begin
            mstep_q <= mstep_q + 5'd1;
          end
        end
        StIdle: begin
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StReduce: begin
        quad_q <= quad;
        tf_q   <= tf_u;
      end
      StDiv: begin
        if (cnt_q == DivLast) begin
          z_q <= base_q + ZWidth'(prod[52:40]);
        end else begin
          x_q    <= XWidth'(tf_q) * ZRemStep + HalfDiv;
          base_q <= ZWidth'(tf_q) * ZPerStep;
        end
      end
      StPoly: begin
        case (pstep_q)
          2'd0:    z2_q <= prod[60:30];
          2'd1:    p_q  <= ZWidth'(SinB - prod[61:30]);
          2'd2:    p_q  <= ZWidth'(SinA - prod[61:30]);
          default: s_q[idx_q] <= s_sig;
        endcase
      end
      StMat: begin
        if (is_mul) begin
          if (dst_t1) begin
            t1_q <= mul30;
          end else begin
            t0_q <= mul30;
          end
        end else begin
          coef_q[cidx] <= to_coef(comb_v);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      coef_o[i] = coef_q[i];
    end
  end

  assign ready_o = valid_q;

endmodule

/* verif/imu_mounting_correction_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_mounting_correction_test
// Drives IMU samples and register writes into the mounting-correction block
// with random bursts and output stalls, and compares every result against a
// fixed-point model of gyro scaling, matrix build and rotation.
// ----------------------------------------------------------------------------
module imu_mounting_correction_test;
  import imc_pkg::*;

  typedef struct packed {
    logic [5:0][15:0] axis;
  } imu_sample_t;

  typedef struct packed {
    logic [5:0][15:0] axis;
    logic             clip;
  } imu_result_t;

  class mount_scoreboard;
    logic [15:0] angle [3];
    logic [15:0] scale [3];
    longint      coef [9];
    imu_result_t corrected_q [$];
    int          errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        angle[i] = 16'd0;
        scale[i] = 16'd16384;
      end
      errors = 0;
      build_matrix();
    endfunction

    function longint round_shift(longint v, int n);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 <<< (n - 1))) >>> n;
      return (v < 0) ? -m : m;
    endfunction

    function longint q30_mul(longint a, longint b);
      longint m;
      m = ((a < 0) ? -a : a) * ((b < 0) ? -b : b);
      m = (m + (64'sd1 <<< 29)) >>> 30;
      return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function longint quarter_sine(longint t);
      longint unsigned z, z2, p;
      z  = ((64'(t) << 30) + 64'd4500) / 64'd9000;
      z2 = (z * z) >> 30;
      p  = 64'd76016977;
      p  = 64'd688904866 - ((p * z2) >> 30);
      p  = 64'd1686629713 - ((p * z2) >> 30);
      return longint'((p * z) >> 30);
    endfunction

    function longint sine_hd(int a);
      int r;
      int q;
      int t;
      r = a % 36000;
      if (r < 0) r += 36000;
      q = r / 9000;
      t = r % 9000;
      case (q)
        0: return quarter_sine(t);
        1: return quarter_sine(9000 - t);
        2: return -quarter_sine(t);
        default: return -quarter_sine(9000 - t);
      endcase
    endfunction

    function void build_matrix();
      int y, p, r;
      longint sy, cy, sp, cp, sr, cr, v;
      longint m [9];
      y  = int'($signed(angle[0]));
      p  = int'($signed(angle[1]));
      r  = int'($signed(angle[2]));
      sy = sine_hd(y);
      cy = sine_hd(y + 9000);
      sp = sine_hd(p);
      cp = sine_hd(p + 9000);
      sr = sine_hd(r);
      cr = sine_hd(r + 9000);
      m[0] = q30_mul(cy, cr) + q30_mul(q30_mul(sy, sp), sr);
      m[1] = q30_mul(cp, sy);
      m[2] = q30_mul(cy, sr) - q30_mul(q30_mul(cr, sy), sp);
      m[3] = q30_mul(q30_mul(cy, sp), sr) - q30_mul(cr, sy);
      m[4] = q30_mul(cy, cp);
      m[5] = -q30_mul(sy, sr) - q30_mul(q30_mul(cy, cr), sp);
      m[6] = -q30_mul(cp, sr);
      m[7] = sp;
      m[8] = q30_mul(cp, cr);
      for (int i = 0; i < 9; i++) begin
        v = round_shift(m[i], 30 - CoefFracBits);
        if (v > 65535) v = 65535;
        if (v < -65536) v = -65536;
        coef[i] = v;
      end
    endfunction

    function void write_reg(int idx, logic [31:0] value);
      if (idx == RegYaw || idx == RegPitch || idx == RegRoll) begin
        angle[idx] = value[15:0];
        build_matrix();
      end else if (idx >= RegScaleX && idx <= RegScaleZ) begin
        scale[idx - RegScaleX] = value[15:0];
      end
    endfunction

    function void note_request(imu_sample_t s);
      longint vec [6];
      longint acc, mag, lim;
      imu_result_t res;
      res.clip = 1'b0;
      for (int i = 0; i < 3; i++) begin
        vec[i] = round_shift(longint'($signed(s.axis[i])) * longint'(scale[i]), ScaleFrac);
        vec[3 + i] = longint'($signed(s.axis[3 + i]));
      end
      for (int k = 0; k < 6; k++) begin
        acc = 0;
        for (int c = 0; c < 3; c++) acc += coef[(k % 3) * 3 + c] * vec[(k / 3) * 3 + c];
        mag = (acc < 0) ? -acc : acc;
        mag = (mag + 16384) >>> CoefFracBits;
        lim = (acc < 0) ? 32768 : 32767;
        if (mag > lim) begin
          mag = lim;
          res.clip = 1'b1;
        end
        res.axis[k] = 16'((acc < 0) ? -mag : mag);
      end
      corrected_q.push_back(res);
    endfunction

    function void check_result(imu_result_t got);
      imu_result_t exp_r;
      if (corrected_q.size() == 0) begin
        $display("%0t: unexpected result, got %h", $time, got);
        errors++;
        return;
      end
      exp_r = corrected_q.pop_front();
      for (int k = 0; k < 6; k++) begin
        if (got.axis[k] !== exp_r.axis[k]) begin
          $display("%0t: axis %0d expected %0d actual %0d", $time, k,
                   $signed(exp_r.axis[k]), $signed(got.axis[k]));
          errors++;
        end
      end
      if (got.clip !== exp_r.clip) begin
        $display("%0t: clipped expected %0d actual %0d", $time, exp_r.clip, got.clip);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [AddrWidth-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, clipped_o;
  logic signed [SampleWidth-1:0] gyro_x_i, gyro_y_i, gyro_z_i;
  logic signed [SampleWidth-1:0] accel_x_i, accel_y_i, accel_z_i;
  logic signed [SampleWidth-1:0] out_gyro_x_o, out_gyro_y_o, out_gyro_z_o;
  logic signed [SampleWidth-1:0] out_accel_x_o, out_accel_y_o, out_accel_z_o;

  mount_scoreboard sb;
  bit hold_req;
  int burst_left;
  int gap_max;
  longint cycles;

  imu_mounting_correction uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .gyro_x_i, .gyro_y_i, .gyro_z_i,
    .accel_x_i, .accel_y_i, .accel_z_i, .out_valid_o, .out_stall_i,
    .out_gyro_x_o, .out_gyro_y_o, .out_gyro_z_o,
    .out_accel_x_o, .out_accel_y_o, .out_accel_z_o, .clipped_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("imu_mounting_correction_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    imu_sample_t s;
    imu_result_t r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        s.axis = {accel_z_i, accel_y_i, accel_x_i, gyro_z_i, gyro_y_i, gyro_x_i};
        sb.note_request(s);
      end
      if (out_valid_o && !out_stall_i) begin
        r.axis = {out_accel_z_o, out_accel_y_o, out_accel_x_o,
                  out_gyro_z_o, out_gyro_y_o, out_gyro_x_o};
        r.clip = clipped_o;
        sb.check_result(r);
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    int win;
    int hold;
    mode = 0;
    win = 0;
    hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold == 0) hold = 500;
      if (hold > 0) begin
        hold--;
        if (hold == 0) hold_req = 1'b0;
        out_stall_i <= 1'b1;
      end else begin
        if (win == 0) begin
          mode = $urandom_range(0, 3);
          win = $urandom_range(16, 96);
        end
        win--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  task automatic reg_write(int idx, logic [15:0] value);
    logic [31:0] word;
    word = {16'($urandom), value};
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= AddrWidth'(idx * 4);
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, word);
  endtask

  task automatic wait_idle();
    while (sb.corrected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // caller is just past a clock edge; valid stays high between back to back requests
  task automatic send_request(imu_sample_t s);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    {accel_z_i, accel_y_i, accel_x_i, gyro_z_i, gyro_y_i, gyro_x_i} <= s.axis;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic stop_sender();
    in_valid_i <= 1'b0;
    burst_left = 0;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic imu_sample_t pick_sample();
    imu_sample_t s;
    for (int k = 0; k < 6; k++) s.axis[k] = pick_value();
    return s;
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 16'(-18000);
      1: return 16'(18000);
      2: return 16'h7fff;
      3: return 16'h8000;
      4: return 16'(9000 * $urandom_range(0, 3));
      5: return 16'($urandom);
      default: return 16'($urandom_range(0, 36000) - 18000);
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'd16384;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_config(logic [15:0] y, logic [15:0] p, logic [15:0] r,
                             logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
    wait_idle();
    reg_write(RegYaw, y);
    reg_write(RegPitch, p);
    reg_write(RegRoll, r);
    reg_write(RegScaleX, gx);
    reg_write(RegScaleY, gy);
    reg_write(RegScaleZ, gz);
  endtask

  initial begin
    imu_sample_t s;
    sb = new();
    cycles = 0;
    hold_req = 1'b0;
    burst_left = 0;
    gap_max = 4;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    {accel_z_i, accel_y_i, accel_x_i, gyro_z_i, gyro_y_i, gyro_x_i} = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: identity matrix, unit scales
    s.axis = '0;
    send_request(s);
    s.axis = {6{16'h7fff}};
    send_request(s);
    s.axis = {6{16'h8000}};
    send_request(s);
    s.axis = {16'h8000, 16'h7fff, 16'h0001, 16'hffff, 16'h8000, 16'h7fff};
    send_request(s);
    stop_sender();

    // full scale and zero scale, yaw and pitch at the range ends
    load_config(16'(18000), 16'(-18000), 16'(9000), 16'hffff, 16'h0000, 16'd16384);
    for (int i = 0; i < 4; i++) send_request(pick_sample());
    stop_sender();
    // angles beyond the range wrap around
    load_config(16'h7fff, 16'h8000, 16'(-9000), 16'hffff, 16'hffff, 16'hffff);
    s.axis = {6{16'h7fff}};
    send_request(s);
    s.axis = {6{16'h8000}};
    send_request(s);
    for (int i = 0; i < 3; i++) send_request(pick_sample());
    stop_sender();
    // same angle rewritten, out-of-map indexes ignored
    wait_idle();
    reg_write(RegYaw, sb.angle[0]);
    reg_write(6, 16'($urandom));
    reg_write(7, 16'($urandom));
    for (int i = 0; i < 4; i++) send_request(pick_sample());
    stop_sender();
    // scale write alone, no recompute
    wait_idle();
    reg_write(RegScaleY, 16'd8192);
    for (int i = 0; i < 4; i++) send_request(pick_sample());
    stop_sender();

    for (int ph = 0; ph < 8; ph++) begin
      load_config(pick_angle(), pick_angle(), pick_angle(),
                  pick_scale(), pick_scale(), pick_scale());
      if ($urandom_range(0, 2) == 0) reg_write($urandom_range(6, 7), 16'($urandom));
      gap_max = (ph % 3 == 0) ? 0 : $urandom_range(1, 8);
      if (ph == 3) hold_req = 1'b1;
      for (int i = 0; i < 110; i++) send_request(pick_sample());
      stop_sender();
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("imu_mounting_correction_test OK");
    end else begin
      $display("imu_mounting_correction_test NOT OK");
    end
    $finish;
  end

endmodule
